>>> rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// Luhn card check package
// Shared types, constants and digit helpers for the Luhn card number check.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int CARD_W        = 63;
    localparam int BIN_W         = 64;           // card number padded to whole steps
    localparam int BITS_PER_STEP = 4;
    localparam int NUM_DIGITS    = 20;           // even, so digits pair up cleanly
    localparam int BCD_W         = NUM_DIGITS * 4;
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
    localparam int SCAN_STEPS    = NUM_DIGITS / 2;

    localparam logic [3:0] CONV_LAST = 4'(CONV_STEPS - 1);
    localparam logic [3:0] SCAN_LAST = 4'(SCAN_STEPS - 1);

    localparam logic [3:0] DD_THRESH = 4'd5;
    localparam logic [3:0] DD_ADJUST = 4'd3;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_AMEX    = 2'd1,
        KIND_MC      = 2'd2,
        KIND_VISA    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CONV = 2'd1,
        S_SCAN = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_conv_cmd;

    typedef struct packed {
        logic       clr;
        logic       en;
        logic [3:0] pair;
    } t_acc_cmd;

    typedef struct packed {
        logic [7:0] sum;
        logic       ok;
        logic [4:0] top;
        logic [3:0] first;
        logic [3:0] second;
    } t_acc_res;

    // Doubled Luhn digit: a two-digit product is folded by subtracting nine.
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [4:0] p;
        p = {d, 1'b0};
        if (p > 5'd9) begin
            p = p - 5'd9;
        end
        return p[3:0];
    endfunction

    function automatic t_kind card_kind(input logic [4:0] count, input logic [3:0] first,
                                        input logic [3:0] second, input logic ok);
        t_kind k;
        k = KIND_INVALID;
        if (count == 5'd15 && first == 4'd3 && (second inside {4'd4, 4'd7})) begin
            k = KIND_AMEX;
        end else if (count == 5'd16 && first == 4'd5 && (second inside {[4'd1:4'd5]})) begin
            k = KIND_MC;
        end else if ((count inside {5'd13, 5'd16}) && first == 4'd4) begin
            k = KIND_VISA;
        end
        if (!ok) begin
            k = KIND_INVALID;
        end
        return k;
    endfunction

endpackage

>>> rtl/lcc_bcd_conv.sv
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-three converter taking four binary bits per step, then a
// digit shifter that hands out two decimal digits per step, lowest first.
// ----------------------------------------------------------------------------
module lcc_bcd_conv (
    input  logic                        i_clk,
    input  lcc_pkg::t_conv_cmd          i_cmd,
    input  logic [lcc_pkg::CARD_W-1:0]  i_card_number,
    output logic [3:0]                  o_digit_even,
    output logic [3:0]                  o_digit_odd
);
    import lcc_pkg::*;

    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [BIN_W-1:0] r_bin, n_bin;

    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        if (i_cmd.load) begin
            n_bcd = '0;
            n_bin = {{(BIN_W - CARD_W){1'b0}}, i_card_number};
        end else if (i_cmd.step) begin
            for (int j = 0; j < BITS_PER_STEP; j++) begin
                for (int d = 0; d < NUM_DIGITS; d++) begin
                    if (n_bcd[4*d +: 4] >= DD_THRESH) begin
                        n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + DD_ADJUST;
                    end
                end
                n_bcd = {n_bcd[BCD_W-2:0], n_bin[BIN_W-1]};
                n_bin = {n_bin[BIN_W-2:0], 1'b0};
            end
        end else if (i_cmd.shift) begin
            n_bcd = {8'd0, r_bcd[BCD_W-1:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_digit_even = r_bcd[3:0];
    assign o_digit_odd  = r_bcd[7:4];

endmodule

>>> rtl/lcc_luhn_acc.sv
// ----------------------------------------------------------------------------
// Luhn accumulator
// Adds one digit pair per step into the Luhn sum and its remainder modulo
// ten, and tracks the highest non-zero digit and the two leading digits.
// ----------------------------------------------------------------------------
module lcc_luhn_acc (
    input  logic              i_clk,
    input  lcc_pkg::t_acc_cmd i_cmd,
    input  logic [3:0]        i_digit_even,
    input  logic [3:0]        i_digit_odd,
    output lcc_pkg::t_acc_res o_res
);
    import lcc_pkg::*;

    logic [7:0] r_sum, n_sum;
    logic [3:0] r_mod, n_mod;
    logic [4:0] r_top, n_top;
    logic [3:0] r_first, n_first;
    logic [3:0] r_second, n_second;
    logic [3:0] r_prev_odd, n_prev_odd;
    logic [4:0] w_pair_val;
    logic [4:0] w_mod_raw;

    // The even digit of a pair stays as it is; the odd one is doubled.
    assign w_pair_val = 5'(i_digit_even) + 5'(luhn_dbl(i_digit_odd));
    assign w_mod_raw  = 5'(r_mod) + w_pair_val;

    always_comb begin
        n_sum      = r_sum;
        n_mod      = r_mod;
        n_top      = r_top;
        n_first    = r_first;
        n_second   = r_second;
        n_prev_odd = r_prev_odd;
        if (i_cmd.clr) begin
            n_sum      = '0;
            n_mod      = '0;
            n_top      = '0;
            n_first    = '0;
            n_second   = '0;
            n_prev_odd = '0;
        end else if (i_cmd.en) begin
            n_sum = r_sum + 8'(w_pair_val);
            if (w_mod_raw >= 5'd20) begin
                n_mod = 4'(w_mod_raw - 5'd20);
            end else if (w_mod_raw >= 5'd10) begin
                n_mod = 4'(w_mod_raw - 5'd10);
            end else begin
                n_mod = w_mod_raw[3:0];
            end
            if (i_digit_odd != 4'd0) begin
                n_top    = {i_cmd.pair, 1'b1};
                n_first  = i_digit_odd;
                n_second = i_digit_even;
            end else if (i_digit_even != 4'd0) begin
                n_top   = {i_cmd.pair, 1'b0};
                n_first = i_digit_even;
                // A one-digit number takes its only digit as the second one.
                n_second = (i_cmd.pair == 4'd0) ? i_digit_even : r_prev_odd;
            end
            n_prev_odd = i_digit_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum      <= n_sum;
        r_mod      <= n_mod;
        r_top      <= n_top;
        r_first    <= n_first;
        r_second   <= n_second;
        r_prev_odd <= n_prev_odd;
    end

    assign o_res.sum    = r_sum;
    assign o_res.ok     = (r_mod == 4'd0);
    assign o_res.top    = r_top;
    assign o_res.first  = r_first;
    assign o_res.second = r_second;

endmodule

>>> rtl/luhn_card_number_check.sv
// ----------------------------------------------------------------------------
// Luhn card number check
// Converts a binary card number to decimal, forms the Luhn sum and check,
// counts the digits and classifies the card by length and prefix.
// ----------------------------------------------------------------------------
// The block takes one request at a time. After a request is accepted, a
// shift-and-add-three converter works through the 63-bit number four bits per
// cycle, then the accumulator walks the 20 decimal digits two per cycle, and
// the done state forms the card kind and loads the output register. A new
// request is taken only once the sequencer is back in idle. The input ready
// is high whenever the sequencer is idle, even while a previous result still
// waits in the output register; the sequencer only holds in its done state if
// that register is still occupied. Leading zeros add nothing to the sum, so
// the digit count is the position of the highest non-zero digit, with zero
// reported as a single digit. The kind is forced to invalid whenever the Luhn
// sum is not a multiple of ten.
// ----------------------------------------------------------------------------
module luhn_card_number_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lcc_pkg::CARD_W-1:0]  i_card_number,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [4:0]                  o_digit_total,
    output logic [7:0]                  o_luhn_sum,
    output logic                        o_luhn_ok,
    output logic [1:0]                  o_card_kind
);
    import lcc_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_o_valid, n_o_valid;
    logic       w_load_out;

    t_conv_cmd  w_conv_cmd;
    t_acc_cmd   w_acc_cmd;
    t_acc_res   w_acc_res;
    logic [3:0] w_digit_even;
    logic [3:0] w_digit_odd;
    logic [4:0] w_count;

    logic [4:0] r_digit_total;
    logic [7:0] r_luhn_sum;
    logic       r_luhn_ok;
    t_kind      r_card_kind;

    lcc_bcd_conv u_conv (
        .i_clk         (i_clk),
        .i_cmd         (w_conv_cmd),
        .i_card_number (i_card_number),
        .o_digit_even  (w_digit_even),
        .o_digit_odd   (w_digit_odd)
    );

    lcc_luhn_acc u_acc (
        .i_clk        (i_clk),
        .i_cmd        (w_acc_cmd),
        .i_digit_even (w_digit_even),
        .i_digit_odd  (w_digit_odd),
        .o_res        (w_acc_res)
    );

    // The highest non-zero digit position plus one gives the digit count.
    assign w_count = 5'(w_acc_res.top + 5'd1);

    // Sequencer: idle, convert, scan digits, hand over the result.
    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        o_ready          = 1'b0;
        w_load_out       = 1'b0;
        w_conv_cmd       = '0;
        w_acc_cmd        = '0;
        w_acc_cmd.pair   = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_conv_cmd.load = 1'b1;
                    w_acc_cmd.clr   = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_CONV;
                end
            end
            S_CONV: begin
                w_conv_cmd.step = 1'b1;
                n_cnt           = r_cnt + 4'd1;
                if (r_cnt == CONV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_conv_cmd.shift = 1'b1;
                w_acc_cmd.en     = 1'b1;
                n_cnt            = r_cnt + 4'd1;
                if (r_cnt == SCAN_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The output register is freed by the consumer taking the result.
    always_comb begin
        n_o_valid = r_o_valid;
        if (w_load_out) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_digit_total <= w_count;
            r_luhn_sum    <= w_acc_res.sum;
            r_luhn_ok     <= w_acc_res.ok;
            r_card_kind   <= card_kind(w_count, w_acc_res.first, w_acc_res.second,
                                       w_acc_res.ok);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_digit_total = r_digit_total;
    assign o_luhn_sum    = r_luhn_sum;
    assign o_luhn_ok     = r_luhn_ok;
    assign o_card_kind   = r_card_kind;

    // An accepted request always starts the conversion.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CONV))
        else $error("accepted request did not start conversion");

    // The step counter never runs past the conversion length.
    a_conv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_cnt <= CONV_LAST))
        else $error("conversion counter out of range");

    // A presented result always has between one and nineteen digits.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_total >= 5'd1 && o_digit_total <= 5'd19))
        else $error("digit count out of range");

    // A failed Luhn check never carries a card kind.
    a_fail_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_luhn_ok) |-> (o_card_kind == KIND_INVALID))
        else $error("card kind set on Luhn failure");

    // An AMEX verdict needs fifteen digits.
    a_amex_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_card_kind == KIND_AMEX) |-> (o_digit_total == 5'd15))
        else $error("AMEX verdict with wrong length");

endmodule
